@@ design/grbk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbk_pkg
// Shared types and codes for the row grouping block: request and result
// codes and the packed payload structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package grbk_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned KEY_W    = 7;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned OCOL_W   = 6;
  localparam int unsigned OROW_W   = 10;
  localparam int unsigned OCNT_W   = 11;
  localparam int unsigned CFG_W    = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FETCH = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MEMBER  = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic             keep;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OCOL_W-1:0] column;
    logic [OROW_W-1:0] row_index;
    logic [OCNT_W-1:0] last_row;
    logic [OCNT_W-1:0] member_count;
    logic              key_error;
    logic              overflow;
  } out_item_t;

endpackage : grbk_pkg

`default_nettype wire

@@ design/grbk_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbk_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module grbk_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : grbk_ram

`default_nettype wire

@@ design/group_rows_by_key.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_rows_by_key
// Groups loaded rows by a 1-based column key and drains them column by
// column on fetch requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item): one request per transfer.
//   A load stores the row and updates its column's count and last row in
//   the LOAD_UPD state; a load with a dropped key stays in idle. A clear,
//   and reset, sweep the whole column table one entry a cycle, with in_stall
//   high; the row store is not cleared.
//   A fetch walks the row store from the current read position, ROW_RD then
//   ROW_CHK per row visited (read port of the row store, then the shared key
//   compare), stops at the first kept match with a member result, else
//   ends with a column summary read from the table; EMIT then moves the
//   result into the output register once it is free, and a done answer needs
//   only that state. In_stall stays high while a request is in progress.
//   Output channel (out_valid / out_stall / out_item): one result per fetch.
//   A waiting result sits in the output register; loads and clears are still
//   taken, and a further fetch waits for that register to drain when the
//   receiver stalls.
//   Configuration (cfg_valid / cfg_ready / cfg_data): columns_in_use, reset
//   value 64, always accepted; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module group_rows_by_key
  import grbk_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned MAX_COLUMNS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ROW_CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned COL_DW = 2 * ROW_CW;
  localparam logic [ROW_CW-1:0] ROWS_FULL = ROW_CW'(MAX_ROWS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(MAX_COLUMNS - 1);
  localparam logic [KEY_W-1:0]  ACT_MAX   =
    (MAX_COLUMNS > 127) ? KEY_W'(127) : KEY_W'(MAX_COLUMNS);

  typedef enum logic [7:0] {
    ST_SWEEP    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_LOAD_UPD = 8'b0000_0100,
    ST_ROW_RD   = 8'b0000_1000,
    ST_ROW_CHK  = 8'b0001_0000,
    ST_COL_RD   = 8'b0010_0000,
    ST_COL_SUM  = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  cols_cfg_r;
  logic [ROW_CW-1:0] rows_loaded_r, rows_loaded_nxt;
  logic [ROW_CW-1:0] pos_r, pos_nxt;
  logic [KEY_W-1:0]  read_col_r, read_col_nxt;
  logic              key_err_r, key_err_nxt;
  logic              ovf_r, ovf_nxt;
  logic [COL_W-1:0]  sweep_ptr_r, sweep_ptr_nxt;
  logic [COL_W-1:0]  load_col_r, load_col_nxt;
  logic              load_keep_r, load_keep_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic [KEY_W-1:0]  active_cols;
  logic              in_xfer;
  logic              key_ok;
  logic              rows_full;
  logic              out_free;

  // Row store ports
  logic              row_wr_en;
  logic [KEY_W:0]    row_wr_data;
  logic              row_rd_en;
  logic [KEY_W:0]    row_rd_data;
  logic [KEY_W-1:0]  row_key;
  logic              row_keep;
  logic              row_match;

  // Column table ports: {member count, last row}
  logic              col_wr_en;
  logic [COL_W-1:0]  col_wr_addr;
  logic [COL_DW-1:0] col_wr_data;
  logic              col_rd_en;
  logic [COL_W-1:0]  col_rd_addr;
  logic [COL_DW-1:0] col_rd_data;
  logic [ROW_CW-1:0] col_cnt;
  logic [ROW_CW-1:0] col_last;

  // Saturate the column count to the table depth.
  assign active_cols = (cols_cfg_r > ACT_MAX) ? ACT_MAX : cols_cfg_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign key_ok    = (in_item.key != '0) && (in_item.key <= active_cols);
  assign rows_full = (rows_loaded_r >= ROWS_FULL);
  assign out_free  = !out_valid_r || !out_stall;

  assign row_key   = row_rd_data[KEY_W-1:0];
  assign row_keep  = row_rd_data[KEY_W];
  // Shared compare: stored key against the column being drained.
  assign row_match = row_keep && (row_key == (read_col_r + KEY_W'(1)));

  assign col_cnt   = col_rd_data[COL_DW-1:ROW_CW];
  assign col_last  = col_rd_data[ROW_CW-1:0];

  // Row store: write on a load, read one row a step during the walk.
  assign row_wr_en   = in_xfer && (in_item.req_type == REQ_LOAD) && !rows_full;
  assign row_wr_data = key_ok ? {in_item.keep, in_item.key} : '0;
  assign row_rd_en   = (state_r == ST_ROW_RD);

  grbk_ram #(
    .DEPTH (MAX_ROWS),
    .AW    (ROW_AW),
    .DW    (KEY_W + 1)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (rows_loaded_r[ROW_AW-1:0]),
    .wr_data (row_wr_data),
    .rd_en   (row_rd_en),
    .rd_addr (pos_r[ROW_AW-1:0]),
    .rd_data (row_rd_data)
  );

  // Column table: sweep to zero, read-modify-write on a load, read for a summary.
  always_comb begin
    col_wr_en   = 1'b0;
    col_wr_addr = sweep_ptr_r;
    col_wr_data = '0;
    if (state_r == ST_SWEEP) begin
      col_wr_en = 1'b1;
    end else if (state_r == ST_LOAD_UPD) begin
      col_wr_en   = 1'b1;
      col_wr_addr = load_col_r;
      col_wr_data = {col_cnt + ROW_CW'(load_keep_r), rows_loaded_r};
    end
  end

  always_comb begin
    if (state_r == ST_IDLE) begin
      col_rd_en   = row_wr_en && key_ok;
      col_rd_addr = COL_W'(in_item.key - KEY_W'(1));
    end else begin
      col_rd_en   = (state_r == ST_COL_RD);
      col_rd_addr = COL_W'(read_col_r);
    end
  end

  grbk_ram #(
    .DEPTH (MAX_COLUMNS),
    .AW    (COL_W),
    .DW    (COL_DW)
  ) u_col_table (
    .clk     (clk),
    .wr_en   (col_wr_en),
    .wr_addr (col_wr_addr),
    .wr_data (col_wr_data),
    .rd_en   (col_rd_en),
    .rd_addr (col_rd_addr),
    .rd_data (col_rd_data)
  );

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    rows_loaded_nxt = rows_loaded_r;
    pos_nxt         = pos_r;
    read_col_nxt    = read_col_r;
    key_err_nxt     = key_err_r;
    ovf_nxt         = ovf_r;
    sweep_ptr_nxt   = sweep_ptr_r;
    load_col_nxt    = load_col_r;
    load_keep_nxt   = load_keep_r;
    res_nxt         = res_r;

    unique case (state_r)
      ST_SWEEP: begin
        sweep_ptr_nxt = sweep_ptr_r + COL_W'(1);
        if (sweep_ptr_r == COL_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_item.req_type)
            REQ_LOAD: begin
              if (rows_full) begin
                ovf_nxt = 1'b1;
              end else begin
                rows_loaded_nxt = rows_loaded_r + ROW_CW'(1);
                if (key_ok) begin
                  load_col_nxt  = COL_W'(in_item.key - KEY_W'(1));
                  load_keep_nxt = in_item.keep;
                  state_nxt     = ST_LOAD_UPD;
                end else begin
                  key_err_nxt = 1'b1;
                end
              end
            end
            REQ_FETCH: begin
              res_nxt      = '0;
              res_nxt.kind = KIND_DONE;
              if (read_col_r >= active_cols) begin
                state_nxt = ST_EMIT;
              end else if (pos_r < rows_loaded_r) begin
                state_nxt = ST_ROW_RD;
              end else begin
                state_nxt = ST_COL_RD;
              end
            end
            REQ_CLEAR: begin
              rows_loaded_nxt = '0;
              pos_nxt         = '0;
              read_col_nxt    = '0;
              key_err_nxt     = 1'b0;
              ovf_nxt         = 1'b0;
              sweep_ptr_nxt   = '0;
              state_nxt       = ST_SWEEP;
            end
            default: begin
              // unused request code: drop
            end
          endcase
        end
      end
      ST_LOAD_UPD: begin
        state_nxt = ST_IDLE;
      end
      ST_ROW_RD: begin
        state_nxt = ST_ROW_CHK;
      end
      ST_ROW_CHK: begin
        pos_nxt = pos_r + ROW_CW'(1);
        if (row_match) begin
          res_nxt.kind      = KIND_MEMBER;
          res_nxt.column    = OCOL_W'(read_col_r);
          res_nxt.row_index = OROW_W'(pos_r);
          state_nxt         = ST_EMIT;
        end else if ((pos_r + ROW_CW'(1)) < rows_loaded_r) begin
          state_nxt = ST_ROW_RD;
        end else begin
          state_nxt = ST_COL_RD;
        end
      end
      ST_COL_RD: begin
        state_nxt = ST_COL_SUM;
      end
      ST_COL_SUM: begin
        res_nxt.kind         = KIND_SUMMARY;
        res_nxt.column       = OCOL_W'(read_col_r);
        res_nxt.last_row     = OCNT_W'(col_last);
        res_nxt.member_count = OCNT_W'(col_cnt);
        read_col_nxt         = read_col_r + KEY_W'(1);
        pos_nxt              = '0;
        state_nxt            = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      cols_cfg_r    <= CFG_W'(64);
      rows_loaded_r <= '0;
      pos_r         <= '0;
      read_col_r    <= '0;
      key_err_r     <= 1'b0;
      ovf_r         <= 1'b0;
      sweep_ptr_r   <= '0;
    end else begin
      state_r       <= state_nxt;
      rows_loaded_r <= rows_loaded_nxt;
      pos_r         <= pos_nxt;
      read_col_r    <= read_col_nxt;
      key_err_r     <= key_err_nxt;
      ovf_r         <= ovf_nxt;
      sweep_ptr_r   <= sweep_ptr_nxt;
      if (cfg_valid && cfg_ready) begin
        cols_cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    load_col_r  <= load_col_nxt;
    load_keep_r <= load_keep_nxt;
    res_r       <= res_nxt;
  end

  // Output register: load the pending result once the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_item_r           <= res_r;
      out_item_r.key_error <= key_err_r;
      out_item_r.overflow  <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Assertions
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_loaded_r <= ROWS_FULL)
    else $error("row count beyond store depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW_CHK) |-> (pos_r < rows_loaded_r))
    else $error("readout walk past the loaded rows");

  a_load_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_item.req_type == REQ_LOAD) && !rows_full)
      |=> (rows_loaded_r == $past(rows_loaded_r) + ROW_CW'(1)))
    else $error("accepted load did not take a row index");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && out_free) |=> out_valid)
    else $error("fetch result not presented");

endmodule : group_rows_by_key

`default_nettype wire
